@@ src/ray_sphere_intersect_defines.svh @@
// Assertion macros for the ray/sphere intersection block.
// Included by the RTL files that carry concurrent checks; needs clk and arst_n in scope.
`ifndef RAY_SPHERE_INTERSECT_DEFINES_SVH
`define RAY_SPHERE_INTERSECT_DEFINES_SVH
`ifndef ASSERT_OFF
`define RSI_CHECK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("rsi check failed");
`define RSI_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("rsi forbidden condition seen");
`else
`define RSI_CHECK(lbl, prop)
`define RSI_NEVER(lbl, expr)
`endif
`endif

@@ src/rsi_pkg.sv @@
// Shared types, constants and fixed-point helpers for the ray/sphere intersection block.
// No dependencies; imported by every module of the block.
package rsi_pkg;

	localparam int WORD_W      = 32;
	localparam int FRAC        = 16;
	localparam int NUM_W       = WORD_W + FRAC;
	localparam int DEN_W       = WORD_W - 1;
	localparam int ROOT_W      = NUM_W / 2;
	localparam int SQ_REM_W    = ROOT_W + 4;
	localparam int DIV_STAGES  = NUM_W;
	localparam int SQRT_STAGES = ROOT_W;
	localparam int NRM_W       = FRAC + 2;
	localparam int IN_W        = 8 * WORD_W;
	localparam int OUT_W       = 200;

	localparam logic [2:0] REG_CX  = 3'd0;
	localparam logic [2:0] REG_CY  = 3'd1;
	localparam logic [2:0] REG_CZ  = 3'd2;
	localparam logic [2:0] REG_RAD = 3'd3;
	localparam logic [2:0] REG_MAT = 3'd4;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [NRM_W-1:0]  nrm_t;

	localparam word_t WMAX   = 32'sh7fff_ffff;
	localparam word_t WMIN   = 32'sh8000_0000;
	localparam word_t ONE_FX = 32'sd65536;

	// Ray as it arrives on the input bus, origin_x in the lowest bits.
	typedef struct packed {
		word_t       far_lim;
		word_t       near_lim;
		word_t [2:0] dir;
		word_t [2:0] org;
	} ray_t;

	function automatic word_t sadd(word_t a, word_t b);
		logic signed [WORD_W:0] s;
		s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
		if (s[WORD_W] != s[WORD_W-1])
			return s[WORD_W] ? WMIN : WMAX;
		return s[WORD_W-1:0];
	endfunction

	function automatic word_t ssub(word_t a, word_t b);
		logic signed [WORD_W:0] s;
		s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
		if (s[WORD_W] != s[WORD_W-1])
			return s[WORD_W] ? WMIN : WMAX;
		return s[WORD_W-1:0];
	endfunction

	function automatic logic [WORD_W-1:0] mag32(word_t x);
		return x[WORD_W-1] ? (~x + 32'd1) : x;
	endfunction

	// Applies a sign to a truncated magnitude and saturates to the word range.
	function automatic word_t sat_mag(logic neg, logic [NUM_W-1:0] m);
		if (neg) begin
			if (m > 48'h0000_8000_0000)
				return WMIN;
			return word_t'(~m[WORD_W-1:0] + 32'd1);
		end
		if (m > 48'h0000_7fff_ffff)
			return WMAX;
		return word_t'(m[WORD_W-1:0]);
	endfunction

	// Scales a full product back to Q16.16, truncating the magnitude.
	function automatic word_t fmul_fin(logic signed [63:0] p);
		logic [63:0] m;
		m = p[63] ? 64'(-p) : 64'(p);
		return sat_mag(p[63], m[63:FRAC]);
	endfunction

	function automatic nrm_t clamp_nrm(word_t q);
		if (q > ONE_FX)
			return nrm_t'(18'sd65536);
		if (q < -ONE_FX)
			return nrm_t'(18'sh30000);
		return q[NRM_W-1:0];
	endfunction

endpackage

@@ src/rsi_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, unsigned magnitudes.
// Depends on rsi_pkg; a sign bit rides along with each quotient.
module rsi_div import rsi_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic             neg_in,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             neg_out,
	output logic [NUM_W-1:0] quo
);

	logic [DEN_W-1:0] rem_q [DIV_STAGES];
	logic [NUM_W-1:0] nq_q  [DIV_STAGES];
	logic [DEN_W-1:0] den_q [DIV_STAGES];
	logic             neg_q [DIV_STAGES];
	logic [DEN_W-1:0] rem_d [DIV_STAGES];
	logic [NUM_W-1:0] nq_d  [DIV_STAGES];
	logic [DEN_W-1:0] den_d [DIV_STAGES];

	// The numerator shifts out at the top while quotient bits shift in at the bottom.
	always_comb begin
		logic [DEN_W:0]   cur;
		logic [DEN_W-1:0] pr;
		logic [NUM_W-1:0] pn;
		logic [DEN_W-1:0] pd;
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (k == 0) begin
				pr = '0;
				pn = num;
				pd = den;
			end else begin
				pr = rem_q[k-1];
				pn = nq_q[k-1];
				pd = den_q[k-1];
			end
			cur = {pr, pn[NUM_W-1]};
			if (cur >= {1'b0, pd}) begin
				rem_d[k] = DEN_W'(cur - {1'b0, pd});
				nq_d[k]  = {pn[NUM_W-2:0], 1'b1};
			end else begin
				rem_d[k] = cur[DEN_W-1:0];
				nq_d[k]  = {pn[NUM_W-2:0], 1'b0};
			end
			den_d[k] = pd;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				rem_q[k] <= rem_d[k];
				nq_q[k]  <= nq_d[k];
				den_q[k] <= den_d[k];
			end
			neg_q[0] <= neg_in;
			for (int k = 1; k < DIV_STAGES; k++)
				neg_q[k] <= neg_q[k-1];
		end
	end

	assign quo     = nq_q[DIV_STAGES-1];
	assign neg_out = neg_q[DIV_STAGES-1];

endmodule

@@ src/rsi_sqrt.sv @@
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Depends on rsi_pkg; root = floor(sqrt(rad)).
module rsi_sqrt import rsi_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [NUM_W-1:0]  rad,
	output logic [ROOT_W-1:0] root
);

	logic [SQ_REM_W-1:0] rem_q  [SQRT_STAGES];
	logic [ROOT_W-1:0]   root_q [SQRT_STAGES];
	logic [NUM_W-1:0]    num_q  [SQRT_STAGES];
	logic [SQ_REM_W-1:0] rem_d  [SQRT_STAGES];
	logic [ROOT_W-1:0]   root_d [SQRT_STAGES];
	logic [NUM_W-1:0]    num_d  [SQRT_STAGES];

	// Each stage brings down two radicand bits and tries the next root bit.
	always_comb begin
		logic [SQ_REM_W-1:0] cur;
		logic [SQ_REM_W-1:0] trial;
		logic [SQ_REM_W-1:0] pr;
		logic [ROOT_W-1:0]   pq;
		logic [NUM_W-1:0]    pn;
		for (int k = 0; k < SQRT_STAGES; k++) begin
			if (k == 0) begin
				pr = '0;
				pq = '0;
				pn = rad;
			end else begin
				pr = rem_q[k-1];
				pq = root_q[k-1];
				pn = num_q[k-1];
			end
			cur   = {pr[SQ_REM_W-3:0], pn[NUM_W-1:NUM_W-2]};
			trial = SQ_REM_W'({pq, 2'b01});
			if (cur >= trial) begin
				rem_d[k]  = cur - trial;
				root_d[k] = {pq[ROOT_W-2:0], 1'b1};
			end else begin
				rem_d[k]  = cur;
				root_d[k] = {pq[ROOT_W-2:0], 1'b0};
			end
			num_d[k] = {pn[NUM_W-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < SQRT_STAGES; k++) begin
				rem_q[k]  <= rem_d[k];
				root_q[k] <= root_d[k];
				num_q[k]  <= num_d[k];
			end
		end
	end

	assign root = root_q[SQRT_STAGES-1];

endmodule

@@ src/ray_sphere_intersect.sv @@
// Ray against one configured sphere, signed Q16.16, one ray per cycle while s_tready is high.
// The pipeline depth is set by the 24-stage square root and the two 48-stage divider
// steps (roots by |d|^2, normal by radius).
// Throughput: one ray per cycle unless stalled; a two-entry output register absorbs a stalled sink.
// Reset clears the sphere registers and all valid bits; the block is ready at once.
// Depends on rsi_pkg, rsi_sqrt, rsi_div and ray_sphere_intersect_defines.svh.
`include "ray_sphere_intersect_defines.svh"
module ray_sphere_intersect import rsi_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [2:0]       wr_index,
	input  logic [31:0]      wr_data,
	input  logic             s_tvalid,
	output logic             s_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, near_limit, far_limit
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// distance, point_x, point_y, point_z, normal_x, normal_y, normal_z,
	// outside-surface flag, hit_material, one pad bit
	output logic [OUT_W-1:0] m_tdata,
	// is_hit
	output logic             m_tuser
);

	typedef struct packed {
		ray_t  ray;
		word_t a;
		word_t negb;
		logic  miss;
	} sq_side_t;

	typedef struct packed {
		word_t [2:0] dir;
		word_t       t;
		word_t [2:0] pt;
		logic        hit;
	} geo_t;

	// Sphere registers.
	word_t       cx_q, cy_q, cz_q;
	logic [30:0] radius_q;
	logic [15:0] material_q;
	word_t       ctr [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q       <= '0;
			cy_q       <= '0;
			cz_q       <= '0;
			radius_q   <= '0;
			material_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_CX:  cx_q       <= wr_data;
				REG_CY:  cy_q       <= wr_data;
				REG_CZ:  cz_q       <= wr_data;
				REG_RAD: radius_q   <= wr_data[30:0];
				REG_MAT: material_q <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	assign ctr[0] = cx_q;
	assign ctr[1] = cy_q;
	assign ctr[2] = cz_q;

	logic en;
	logic out_v_q, skid_v_q;
	assign en       = !skid_v_q;
	assign s_tready = en;

	// Valid bits of the fixed stages.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic v_s11, v_s12, v_s13, v_s14, v_s15, v_s16, v_s17, v_s18;
	logic [SQRT_STAGES-1:0] sq_vld_q;
	logic [DIV_STAGES-1:0]  dv1_vld_q;
	logic [DIV_STAGES-1:0]  dv2_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
			{v_s10, v_s11, v_s12, v_s13, v_s14, v_s15, v_s16, v_s17, v_s18} <= '0;
			sq_vld_q  <= '0;
			dv1_vld_q <= '0;
			dv2_vld_q <= '0;
		end else if (en) begin
			v_s1      <= s_tvalid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			v_s6      <= v_s5;
			v_s7      <= v_s6;
			v_s8      <= v_s7;
			sq_vld_q  <= {sq_vld_q[SQRT_STAGES-2:0], v_s8};
			v_s9      <= sq_vld_q[SQRT_STAGES-1];
			dv1_vld_q <= {dv1_vld_q[DIV_STAGES-2:0], v_s9};
			v_s10     <= dv1_vld_q[DIV_STAGES-1];
			v_s11     <= v_s10;
			v_s12     <= v_s11;
			v_s13     <= v_s12;
			v_s14     <= v_s13;
			v_s15     <= v_s14;
			dv2_vld_q <= {dv2_vld_q[DIV_STAGES-2:0], v_s15};
			v_s16     <= dv2_vld_q[DIV_STAGES-1];
			v_s17     <= v_s16;
			v_s18     <= v_s17;
		end
	end

	// Stages 1 to 8: dot products, c and the discriminant.
	ray_t              in_ray;
	ray_t              ray_s1, ray_s2, ray_s3, ray_s4, ray_s5, ray_s6, ray_s7, ray_s8;
	word_t             oc_s1 [3];
	logic signed [63:0] pdd_s2 [3], pod_s2 [3], poo_s2 [3];
	logic signed [63:0] prr_s2;
	word_t             fdd_s3 [3], fod_s3 [3], foo_s3 [3];
	word_t             frr_s3;
	word_t             a_s4, hb_s4, oo_s4, rr_s4;
	word_t             a_s5, hb_s5, c_s5;
	logic              miss_s5, miss_s6, miss_s7, miss_s8;
	logic signed [63:0] phh_s6, pac_s6;
	word_t             a_s6, negb_s6, a_s7, negb_s7, hh_s7, ac_s7;
	word_t             a_s8, negb_s8, disc_s8, disc_c;

	assign in_ray = ray_t'(s_tdata);
	assign disc_c = ssub(hh_s7, ac_s7);

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s1 <= in_ray;
			for (int i = 0; i < 3; i++)
				oc_s1[i] <= ssub(in_ray.org[i], ctr[i]);

			ray_s2 <= ray_s1;
			for (int i = 0; i < 3; i++) begin
				pdd_s2[i] <= $signed(ray_s1.dir[i]) * $signed(ray_s1.dir[i]);
				pod_s2[i] <= oc_s1[i] * $signed(ray_s1.dir[i]);
				poo_s2[i] <= oc_s1[i] * oc_s1[i];
			end
			prr_s2 <= $signed({1'b0, radius_q}) * $signed({1'b0, radius_q});

			ray_s3 <= ray_s2;
			for (int i = 0; i < 3; i++) begin
				fdd_s3[i] <= fmul_fin(pdd_s2[i]);
				fod_s3[i] <= fmul_fin(pod_s2[i]);
				foo_s3[i] <= fmul_fin(poo_s2[i]);
			end
			frr_s3 <= fmul_fin(prr_s2);

			ray_s4 <= ray_s3;
			a_s4   <= sadd(sadd(fdd_s3[0], fdd_s3[1]), fdd_s3[2]);
			hb_s4  <= sadd(sadd(fod_s3[0], fod_s3[1]), fod_s3[2]);
			oo_s4  <= sadd(sadd(foo_s3[0], foo_s3[1]), foo_s3[2]);
			rr_s4  <= frr_s3;

			ray_s5  <= ray_s4;
			a_s5    <= a_s4;
			hb_s5   <= hb_s4;
			c_s5    <= ssub(oo_s4, rr_s4);
			miss_s5 <= (radius_q == '0) || (a_s4 <= 32'sd0);

			ray_s6  <= ray_s5;
			a_s6    <= a_s5;
			miss_s6 <= miss_s5;
			phh_s6  <= hb_s5 * hb_s5;
			pac_s6  <= a_s5 * c_s5;
			negb_s6 <= ssub(32'sd0, hb_s5);

			ray_s7  <= ray_s6;
			a_s7    <= a_s6;
			miss_s7 <= miss_s6;
			negb_s7 <= negb_s6;
			hh_s7   <= fmul_fin(phh_s6);
			ac_s7   <= fmul_fin(pac_s6);

			ray_s8  <= ray_s7;
			a_s8    <= a_s7;
			negb_s8 <= negb_s7;
			disc_s8 <= disc_c;
			miss_s8 <= miss_s7 || disc_c[WORD_W-1];
		end
	end

	// Square root of the discriminant, scaled by 2^FRAC.
	logic [ROOT_W-1:0] sq_root;
	sq_side_t          sq_line_q [SQRT_STAGES];

	rsi_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  ({1'b0, disc_s8[WORD_W-2:0], {FRAC{1'b0}}}),
		.root (sq_root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sq_line_q[0] <= '{ray: ray_s8, a: a_s8, negb: negb_s8, miss: miss_s8};
			for (int k = 1; k < SQRT_STAGES; k++)
				sq_line_q[k] <= sq_line_q[k-1];
		end
	end

	// Stage 9: numerators of both roots.
	word_t            sq_w, n1_c, n2_c;
	sq_side_t         side_s9;
	logic             neg1_s9, neg2_s9;
	logic [NUM_W-1:0] num1_s9, num2_s9;

	assign sq_w = word_t'({{(WORD_W-ROOT_W){1'b0}}, sq_root});
	assign n1_c = ssub(sq_line_q[SQRT_STAGES-1].negb, sq_w);
	assign n2_c = sadd(sq_line_q[SQRT_STAGES-1].negb, sq_w);

	always_ff @(posedge clk) begin
		if (en) begin
			side_s9 <= sq_line_q[SQRT_STAGES-1];
			neg1_s9 <= n1_c[WORD_W-1];
			neg2_s9 <= n2_c[WORD_W-1];
			num1_s9 <= {mag32(n1_c), {FRAC{1'b0}}};
			num2_s9 <= {mag32(n2_c), {FRAC{1'b0}}};
		end
	end

	// Both roots divided by a in parallel.
	logic             rneg1, rneg2;
	logic [NUM_W-1:0] rquo1, rquo2;
	sq_side_t         dv1_line_q [DIV_STAGES];

	rsi_div u_div_near (
		.clk     (clk),
		.en      (en),
		.neg_in  (neg1_s9),
		.num     (num1_s9),
		.den     (side_s9.a[DEN_W-1:0]),
		.neg_out (rneg1),
		.quo     (rquo1)
	);

	rsi_div u_div_far (
		.clk     (clk),
		.en      (en),
		.neg_in  (neg2_s9),
		.num     (num2_s9),
		.den     (side_s9.a[DEN_W-1:0]),
		.neg_out (rneg2),
		.quo     (rquo2)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			dv1_line_q[0] <= side_s9;
			for (int k = 1; k < DIV_STAGES; k++)
				dv1_line_q[k] <= dv1_line_q[k-1];
		end
	end

	// Stages 10 to 15: root choice, hit point and normal numerators.
	sq_side_t           side_s10;
	word_t              t1_s10, t2_s10;
	logic               in1_c, in2_c;
	ray_t               ray_s11, ray_s12, ray_s13;
	word_t              t_s11, t_s12, t_s13, t_s14;
	logic               hit_s11, hit_s12, hit_s13, hit_s14;
	logic signed [63:0] ptd_s12 [3];
	word_t              ptd_s13 [3];
	word_t              pt_s14 [3];
	word_t [2:0]        dir_s14;
	geo_t               geo_s15;
	logic               nneg_s15 [3];
	logic [NUM_W-1:0]   nnum_s15 [3];
	word_t              dn_c [3];

	assign in1_c = !((t1_s10 < side_s10.ray.near_lim) || (side_s10.ray.far_lim < t1_s10));
	assign in2_c = !((t2_s10 < side_s10.ray.near_lim) || (side_s10.ray.far_lim < t2_s10));

	always_comb begin
		for (int i = 0; i < 3; i++)
			dn_c[i] = ssub(pt_s14[i], ctr[i]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s10 <= dv1_line_q[DIV_STAGES-1];
			t1_s10   <= sat_mag(rneg1, rquo1);
			t2_s10   <= sat_mag(rneg2, rquo2);

			ray_s11 <= side_s10.ray;
			t_s11   <= in1_c ? t1_s10 : t2_s10;
			hit_s11 <= !side_s10.miss && (in1_c || in2_c);

			ray_s12 <= ray_s11;
			t_s12   <= t_s11;
			hit_s12 <= hit_s11;
			for (int i = 0; i < 3; i++)
				ptd_s12[i] <= t_s11 * $signed(ray_s11.dir[i]);

			ray_s13 <= ray_s12;
			t_s13   <= t_s12;
			hit_s13 <= hit_s12;
			for (int i = 0; i < 3; i++)
				ptd_s13[i] <= fmul_fin(ptd_s12[i]);

			dir_s14 <= ray_s13.dir;
			t_s14   <= t_s13;
			hit_s14 <= hit_s13;
			for (int i = 0; i < 3; i++)
				pt_s14[i] <= sadd(ray_s13.org[i], ptd_s13[i]);

			geo_s15.dir <= dir_s14;
			geo_s15.t   <= t_s14;
			geo_s15.hit <= hit_s14;
			for (int i = 0; i < 3; i++) begin
				geo_s15.pt[i] <= pt_s14[i];
				nneg_s15[i]   <= dn_c[i][WORD_W-1];
				nnum_s15[i]   <= {mag32(dn_c[i]), {FRAC{1'b0}}};
			end
		end
	end

	// Normal components divided by the radius.
	logic             nneg [3];
	logic [NUM_W-1:0] nquo [3];
	geo_t             dv2_line_q [DIV_STAGES];

	for (genvar g = 0; g < 3; g++) begin : g_nrm_div
		rsi_div u_div (
			.clk     (clk),
			.en      (en),
			.neg_in  (nneg_s15[g]),
			.num     (nnum_s15[g]),
			.den     (radius_q),
			.neg_out (nneg[g]),
			.quo     (nquo[g])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv2_line_q[0] <= geo_s15;
			for (int k = 1; k < DIV_STAGES; k++)
				dv2_line_q[k] <= dv2_line_q[k-1];
		end
	end

	// Stages 16 to 18: clamp the normal and test which side faces the ray.
	geo_t               geo_s16, geo_s17, geo_s18;
	nrm_t               nrm_s16 [3], nrm_s17 [3], nrm_s18 [3];
	logic signed [63:0] pdn_s17 [3];
	word_t              fdn_s18 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s16 <= dv2_line_q[DIV_STAGES-1];
			for (int i = 0; i < 3; i++)
				nrm_s16[i] <= clamp_nrm(sat_mag(nneg[i], nquo[i]));

			geo_s17 <= geo_s16;
			for (int i = 0; i < 3; i++) begin
				nrm_s17[i] <= nrm_s16[i];
				pdn_s17[i] <= $signed(geo_s16.dir[i]) * nrm_s16[i];
			end

			geo_s18 <= geo_s17;
			for (int i = 0; i < 3; i++) begin
				nrm_s18[i] <= nrm_s17[i];
				fdn_s18[i] <= fmul_fin(pdn_s17[i]);
			end
		end
	end

	// Final assembly of the result; a miss reports all zeros.
	word_t            dot_c;
	logic             front_c;
	nrm_t             nf_c [3];
	logic [OUT_W-1:0] res_c;

	assign dot_c   = sadd(sadd(fdn_s18[0], fdn_s18[1]), fdn_s18[2]);
	assign front_c = dot_c[WORD_W-1];

	always_comb begin
		for (int i = 0; i < 3; i++)
			nf_c[i] = front_c ? nrm_s18[i] : nrm_t'(-nrm_s18[i]);
	end

	assign res_c = geo_s18.hit ?
		{1'b0, material_q, front_c, nf_c[2], nf_c[1], nf_c[0],
		 geo_s18.pt[2], geo_s18.pt[1], geo_s18.pt[0], geo_s18.t} : '0;

	// Output register with one skid entry behind it.
	logic             push, pop;
	logic [OUT_W-1:0] out_data_q, skid_data_q;
	logic             out_hit_q, skid_hit_q;

	assign pop  = out_v_q && m_tready;
	assign push = en && v_s18;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || pop) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || pop) begin
			if (skid_v_q) begin
				out_data_q <= skid_data_q;
				out_hit_q  <= skid_hit_q;
			end else begin
				out_data_q <= res_c;
				out_hit_q  <= geo_s18.hit;
			end
		end else if (push) begin
			skid_data_q <= res_c;
			skid_hit_q  <= geo_s18.hit;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_hit_q;

	logic nrm_ok_c;
	assign nrm_ok_c = (nrm_s18[0] <= 18'sd65536) && (nrm_s18[0] >= -18'sd65536) &&
		(nrm_s18[1] <= 18'sd65536) && (nrm_s18[1] >= -18'sd65536) &&
		(nrm_s18[2] <= 18'sd65536) && (nrm_s18[2] >= -18'sd65536);

	`RSI_NEVER(a_skid_without_out, skid_v_q && !out_v_q)
	`RSI_CHECK(a_miss_is_zero, (m_tvalid && !m_tuser) |-> (m_tdata == '0))
	`RSI_CHECK(a_stall_freezes, !en |=> ($stable(v_s18) && $stable(t_s11)))
	`RSI_CHECK(a_normal_bounded, (push && geo_s18.hit) |-> nrm_ok_c)

endmodule
